FILE: src/bcas_pkg.sv
// Shared types and constants for the binary cellular automaton smoother.
`timescale 1ns / 1ps
`default_nettype none
package bcas_pkg;

  localparam int MAX_LINE  = 256;
  localparam int MAX_LINES = 256;

  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int ROW_W     = $clog2(MAX_LINES + 2);
  localparam int SIZE_W    = 9;
  localparam int THR_W     = 4;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 9;
  localparam int TDATA_W   = 8;

  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

  typedef logic [2:0] column_t;

  // bit0 top, bit1 middle, bit2 bottom
  localparam column_t WALL_COLUMN = 3'b111;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_LENGTH    = 2'd0,
    REG_LINE_COUNT     = 2'd1,
    REG_WALL_KEEP_MIN  = 2'd2,
    REG_FLOOR_KEEP_MAX = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic restart;
    logic advance;
    logic line_start;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: src/binary_cellular_automaton_smoother.sv
// Top level of the binary cellular automaton smoother.
`timescale 1ns / 1ps
`default_nettype none
// One smoothing pass over a wall/floor raster fed in raster order, one cell per
// item, with one item accepted per clock when the output side keeps up. Each
// result leaves line_length+1 items after its cell; send line_length+1 flush
// items after the last cell to drain the frame, the last result carrying tlast.
// Edges count as wall. The two previous lines sit in a 256 x 2 line store that
// is read one column ahead, so the store port sets the one-cell-per-clock
// figure; the 3x3 window is a row of column cells shifting each item. Results
// appear on the output register in the cycle after the item is taken. Writing
// line_length or line_count restarts the frame; write registers only when idle.
// Config: index 0 line_length, 1 line_count, 2 wall_keep_min, 3 floor_keep_max.
module binary_cellular_automaton_smoother (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [bcas_pkg::TDATA_W-1:0]       in_tdata,   // [0] wall_in
  input  wire logic                               in_tuser,   // [0] flush
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [bcas_pkg::TDATA_W-1:0]       out_tdata,  // [0] wall_out
  output logic                                    out_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bcas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bcas_pkg::CFG_W-1:0]         cfg_data
);

  localparam int COL_W  = bcas_pkg::COL_W;
  localparam int ROW_W  = bcas_pkg::ROW_W;
  localparam int SIZE_W = bcas_pkg::SIZE_W;
  localparam int THR_W  = bcas_pkg::THR_W;

  // configuration
  logic [SIZE_W-1:0] line_length_r, line_length_nxt;
  logic [SIZE_W-1:0] line_count_r, line_count_nxt;
  logic [THR_W-1:0]  wall_keep_min_r, wall_keep_min_nxt;
  logic [THR_W-1:0]  floor_keep_max_r, floor_keep_max_nxt;
  logic              cfg_fire;
  logic              size_write;

  // counters
  logic [COL_W-1:0]  column_count_r, column_count_nxt;
  logic [ROW_W-1:0]  row_count_r, row_count_nxt;
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    len_w;
  logic [ROW_W:0]    lines_w;
  logic [ROW_W:0]    lines_p1;
  logic              line_start;
  logic              frame_done;
  logic              in_fire;
  logic              wall_in;

  // line store and window
  logic [1:0]            store_q;
  logic [1:0]            store_wdata;
  logic                  store_we;
  bcas_pkg::column_t     col;
  bcas_pkg::column_t     cell0_q;
  bcas_pkg::column_t     cell1_q;
  bcas_pkg::cell_ctl_t   cell_ctl;
  logic [8:0]            win;
  logic                  emit;
  logic                  rule_wall;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_wall_r, out_wall_nxt;
  logic out_last_r, out_last_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign size_write = cfg_fire &&
                      ((bcas_pkg::cfg_reg_t'(cfg_index) == bcas_pkg::REG_LINE_LENGTH) ||
                       (bcas_pkg::cfg_reg_t'(cfg_index) == bcas_pkg::REG_LINE_COUNT));

  always_comb begin
    line_length_nxt    = line_length_r;
    line_count_nxt     = line_count_r;
    wall_keep_min_nxt  = wall_keep_min_r;
    floor_keep_max_nxt = floor_keep_max_r;
    if (cfg_fire) begin
      unique case (bcas_pkg::cfg_reg_t'(cfg_index))
        bcas_pkg::REG_LINE_LENGTH:    line_length_nxt    = cfg_data[SIZE_W-1:0];
        bcas_pkg::REG_LINE_COUNT:     line_count_nxt     = cfg_data[SIZE_W-1:0];
        bcas_pkg::REG_WALL_KEEP_MIN:  wall_keep_min_nxt  = cfg_data[THR_W-1:0];
        bcas_pkg::REG_FLOOR_KEEP_MAX: floor_keep_max_nxt = cfg_data[THR_W-1:0];
      endcase
    end
  end

  // clamped frame sizes
  always_comb begin
    if (line_length_r < bcas_pkg::MIN_SIZE) begin
      len_w = (COL_W+1)'(3);
    end else if (int'(line_length_r) > bcas_pkg::MAX_LINE) begin
      len_w = (COL_W+1)'(bcas_pkg::MAX_LINE);
    end else begin
      len_w = (COL_W+1)'(line_length_r);
    end
    if (line_count_r < bcas_pkg::MIN_SIZE) begin
      lines_w = (ROW_W+1)'(3);
    end else if (int'(line_count_r) > bcas_pkg::MAX_LINES) begin
      lines_w = (ROW_W+1)'(bcas_pkg::MAX_LINES);
    end else begin
      lines_w = (ROW_W+1)'(line_count_r);
    end
  end

  assign lines_p1   = lines_w + (ROW_W+1)'(1);
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign wall_in    = in_tdata[0];
  assign line_start = (column_count_r == '0);
  assign frame_done = ({1'b0, row_count_r} >= lines_p1);
  assign col_inc    = {1'b0, column_count_r} + (COL_W+1)'(1);

  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    priority if (size_write) begin
      column_count_nxt = '0;
      row_count_nxt    = '0;
    end else if (in_fire) begin
      if (frame_done) begin
        column_count_nxt = '0;
        row_count_nxt    = '0;
      end else if (col_inc >= len_w) begin
        column_count_nxt = '0;
        row_count_nxt    = row_count_r + ROW_W'(1);
      end else begin
        column_count_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // store is read at the column of the next item, so store_q matches column_count_r
  assign store_we    = in_fire && ({1'b0, row_count_r} < lines_w);
  assign store_wdata = {store_q[0], wall_in};

  bcas_ram #(
    .WIDTH (2),
    .DEPTH (bcas_pkg::MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (column_count_r),
    .wdata (store_wdata),
    .raddr (column_count_nxt),
    .rdata (store_q)
  );

  always_comb begin
    col[0] = (row_count_r >= ROW_W'(2)) ? store_q[1] : 1'b1;
    col[1] = (row_count_r >= ROW_W'(1)) ? store_q[0] : 1'b1;
    col[2] = ({1'b0, row_count_r} < lines_w) ? wall_in : 1'b1;
  end

  // the oldest window column is only ever shifted out, so two cells carry the state
  assign cell_ctl.restart    = size_write || (in_fire && frame_done);
  assign cell_ctl.advance    = in_fire;
  assign cell_ctl.line_start = line_start;

  bcas_cell u_cell0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .shift_in (col),
    .fill_in  (col),
    .col_q    (cell0_q)
  );

  bcas_cell u_cell1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .shift_in (cell0_q),
    .fill_in  (bcas_pkg::WALL_COLUMN),
    .col_q    (cell1_q)
  );

  // at a line start the finished line is closed with a wall column on its right
  assign win  = line_start ? {bcas_pkg::WALL_COLUMN, cell0_q, cell1_q}
                           : {col, cell0_q, cell1_q};
  assign emit = line_start ? (row_count_r >= ROW_W'(2)) : (row_count_r >= ROW_W'(1));

  bcas_rule u_rule (
    .win            (win),
    .wall_keep_min  (wall_keep_min_r),
    .floor_keep_max (floor_keep_max_r),
    .wall           (rule_wall)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_wall_nxt  = out_wall_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && emit) begin
      out_valid_nxt = 1'b1;
      out_wall_nxt  = rule_wall;
      out_last_nxt  = ({1'b0, row_count_r} == lines_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r    <= SIZE_W'(64);
      line_count_r     <= SIZE_W'(64);
      wall_keep_min_r  <= THR_W'(3);
      floor_keep_max_r <= THR_W'(4);
      column_count_r   <= '0;
      row_count_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      line_length_r    <= line_length_nxt;
      line_count_r     <= line_count_nxt;
      wall_keep_min_r  <= wall_keep_min_nxt;
      floor_keep_max_r <= floor_keep_max_nxt;
      column_count_r   <= column_count_nxt;
      row_count_r      <= row_count_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_wall_r <= out_wall_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bcas_pkg::TDATA_W-1){1'b0}}, out_wall_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, column_count_r} < len_w)
    else $error("column count beyond line length");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_count_r} <= lines_p1)
    else $error("row count beyond drain line");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && frame_done) |=> (row_count_r == '0 && column_count_r == '0))
    else $error("frame did not restart after its last item");

  a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit) |=> out_tvalid)
    else $error("result lost");
`endif

endmodule
`default_nettype wire

FILE: src/bcas_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bcas_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/bcas_cell.sv
// One window column cell: holds a 3-cell column and hands it on to its neighbour.
`timescale 1ns / 1ps
`default_nettype none
module bcas_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bcas_pkg::cell_ctl_t ctl,
  input  wire bcas_pkg::column_t   shift_in,
  input  wire bcas_pkg::column_t   fill_in,
  output bcas_pkg::column_t        col_q
);

  bcas_pkg::column_t col_r;
  bcas_pkg::column_t col_nxt;

  always_comb begin
    col_nxt = col_r;
    priority if (ctl.restart) begin
      col_nxt = '0;
    end else if (ctl.advance) begin
      col_nxt = ctl.line_start ? fill_in : shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign col_q = col_r;

endmodule
`default_nettype wire

FILE: src/bcas_rule.sv
// Neighbour count and keep/flip rule for one 3x3 window.
`timescale 1ns / 1ps
`default_nettype none
module bcas_rule (
  input  wire logic [8:0]                 win,
  input  wire logic [bcas_pkg::THR_W-1:0] wall_keep_min,
  input  wire logic [bcas_pkg::THR_W-1:0] floor_keep_max,
  output logic                            wall
);

  logic [bcas_pkg::CNT_W-1:0] count;

  always_comb begin
    count = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        count = count + bcas_pkg::CNT_W'(win[i]);
      end
    end
  end

  assign wall = win[4] ? (count >= wall_keep_min) : (count > floor_keep_max);

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the binary cellular automaton smoother.
`timescale 1ns / 1ps

module tb_top;
  import bcas_pkg::*;

  localparam int LIMIT         = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int SMALL_ITEMS   = 260;

  typedef struct packed {
    logic wall;
    logic flush;
    logic has_res;
    logic res_wall;
    logic res_end;
  } demo_row_t;

  typedef struct packed {
    logic typed;
    logic has_res;
    logic res_wall;
    logic res_end;
  } item_note_t;

  typedef struct packed {
    logic wall;
    logic frame_end;
  } smoothed_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid  = 1'b0;
  cfg_reg_t             cfg_index  = REG_LINE_LENGTH;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_tready;
  logic                 out_tvalid;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tlast;
  logic                 cfg_ready;

  // shadow of the block: registers, two-line store, window and raster position
  logic [8:0]  len_reg   = 9'd64;
  logic [8:0]  lines_reg = 9'd64;
  logic [3:0]  wall_min  = 4'd3;
  logic [3:0]  floor_max = 4'd4;
  logic [1:0]  prev_lines [MAX_LINE] = '{default: 2'b00};
  logic [8:0]  window    = '0;
  int          col_pos   = 0;
  int          row_pos   = 0;

  item_note_t  notes_q [$];
  smoothed_t   smoothed_q [$];
  int          errors      = 0;
  int          small_items = 0;
  int          cycles      = 0;
  bit          quiet_in    = 1'b0;
  bit          quiet_out   = 1'b0;
  bit          long_hold   = 1'b0;

  binary_cellular_automaton_smoother uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] wall_in
    .in_tuser   (in_tuser),   // [0] flush
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] wall_out
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int eff_size(input logic [8:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [3:0] rand_threshold();
    case ($urandom_range(0, 5))
      0: return 4'd0;
      1: return 4'd15;
      default: return 4'($urandom_range(0, 12));
    endcase
  endfunction

  task automatic restart_raster();
    window  = '0;
    col_pos = 0;
    row_pos = 0;
  endtask

  // one accepted item through the shadow; edges beyond the frame read as wall
  task automatic smooth_step(input logic cur, output logic emit, output logic w,
                             output logic fe);
    int         len;
    int         lines;
    int         ones;
    logic [2:0] column;
    logic [8:0] view;
    logic       top;
    logic       mid;
    logic       bot;
    len   = eff_size(len_reg, MAX_LINE);
    lines = eff_size(lines_reg, MAX_LINES);
    top = (row_pos >= 2) ? prev_lines[col_pos][1] : 1'b1;
    mid = (row_pos >= 1) ? prev_lines[col_pos][0] : 1'b1;
    bot = (row_pos < lines) ? cur : 1'b1;
    column = {bot, mid, top};
    if (row_pos < lines) prev_lines[col_pos] = {prev_lines[col_pos][0], cur};
    if (col_pos == 0) begin
      // finished line closes against a wall column, new line opens with one
      view   = {WALL_COLUMN, window[8:3]};
      emit   = (row_pos >= 2);
      window = {column, WALL_COLUMN, 3'b000};
    end else begin
      window = {column, window[8:3]};
      view   = window;
      emit   = (row_pos >= 1);
    end
    ones = $countones(view) - view[4];
    w    = view[4] ? (ones >= wall_min) : (ones > floor_max);
    fe   = (row_pos == lines + 1);
    if (row_pos >= lines + 1) begin
      restart_raster();
    end else begin
      col_pos++;
      if (col_pos >= len) begin
        col_pos = 0;
        row_pos++;
      end
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LINE_LENGTH: begin
        len_reg = val;
        restart_raster();
      end
      REG_LINE_COUNT: begin
        lines_reg = val;
        restart_raster();
      end
      REG_WALL_KEEP_MIN:  wall_min  = val[3:0];
      REG_FLOOR_KEEP_MAX: floor_max = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic feed(input logic wall, input logic flush, input item_note_t note);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    notes_q.push_back(note);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-1){1'b0}}, wall};
    in_tuser  <= flush;
    do @(posedge clk); while (!in_tready);
  endtask

  // results reach the output register in the cycle after the item; items at row 0 give none
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [8:0] len_v, input logic [8:0] lines_v,
                           input logic [3:0] wk, input logic [3:0] fk,
                           input bit big, input bit press);
    int         len;
    int         lines;
    int         frames;
    int         density;
    int         total;
    int         stop_at;
    item_note_t plain;
    plain     = '0;
    quiet_in  = press || ($urandom_range(0, 3) == 0);
    quiet_out = !press && ($urandom_range(0, 3) == 0);
    write_reg(REG_WALL_KEEP_MIN, 9'(wk));
    write_reg(REG_FLOOR_KEEP_MAX, 9'(fk));
    write_reg(REG_LINE_LENGTH, len_v);
    write_reg(REG_LINE_COUNT, lines_v);
    long_hold = press;
    len    = eff_size(len_v, MAX_LINE);
    lines  = eff_size(lines_v, MAX_LINES);
    frames = big ? 1 : $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      density = $urandom_range(0, 100);
      total   = len * lines + len + 1;
      // a wide frame stops four items into its third line; small ones are cut now and
      // then, left abandoned by the next size write
      if (big)
        stop_at = (2 * len + 4 < total) ? 2 * len + 4 : total;
      else
        stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
      for (int k = 0; k < stop_at; k++) begin
        if (k < len * lines)
          feed($urandom_range(0, 99) < density, $urandom_range(0, 15) == 0, plain);
        else
          feed(1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0, plain);
        if (!big) small_items++;
      end
      if (stop_at < total) break;
      // stray items after the drain open a fresh frame
      if (!big && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          feed(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), plain);
          small_items++;
        end
      end
    end
    settle();
  endtask

  always @(posedge clk) begin : watch
    smoothed_t  exp_c;
    item_note_t note;
    logic       emit;
    logic       w;
    logic       fe;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (smoothed_q.size() == 0) begin
          $error("unexpected item: wall_out %0b frame_end %0b", out_tdata[0], out_tlast);
          errors++;
        end else begin
          exp_c = smoothed_q.pop_front();
          if (out_tdata[0] !== exp_c.wall) begin
            $error("wall_out: expected %0b, got %0b", exp_c.wall, out_tdata[0]);
            errors++;
          end
          if (out_tlast !== exp_c.frame_end) begin
            $error("frame_end: expected %0b, got %0b", exp_c.frame_end, out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        note = notes_q.pop_front();
        smooth_step(in_tdata[0], emit, w, fe);
        if (note.typed) begin
          emit = note.has_res;
          w    = note.res_wall;
          fe   = note.res_end;
        end
        if (emit) smoothed_q.push_back('{wall: w, frame_end: fe});
      end
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = quiet_out ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    demo_row_t  demo [26];
    item_note_t note;
    logic [8:0] lv;
    logic [8:0] cv;
    int         phase_no;
    // wall, flush, has_res, res_wall, res_end; 3x3 frames (sizes below range)
    demo = '{
      // solid rock: every cell keeps eight wall neighbours
      '{1, 0, 0, 0, 0}, '{1, 0, 0, 0, 0}, '{1, 0, 0, 0, 0}, '{1, 0, 0, 0, 0},
      '{1, 0, 1, 1, 0}, '{1, 0, 1, 1, 0}, '{1, 0, 1, 1, 0}, '{1, 0, 1, 1, 0},
      '{1, 0, 1, 1, 0},
      '{0, 1, 1, 1, 0}, '{0, 1, 1, 1, 0}, '{0, 1, 1, 1, 0}, '{0, 1, 1, 1, 1},
      // open floor: corners see edge walls above floor_keep_max and close, the rest stay open;
      // flush set on cells and wall set on drain items, both ignored
      '{0, 1, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 1, 0, 0, 0},
      '{0, 0, 1, 1, 0}, '{0, 0, 1, 0, 0}, '{0, 1, 1, 1, 0}, '{0, 0, 1, 0, 0},
      '{0, 0, 1, 0, 0},
      '{1, 0, 1, 0, 0}, '{1, 0, 1, 1, 0}, '{1, 0, 1, 0, 0}, '{1, 0, 1, 1, 1}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_LINE_LENGTH, 9'd0);
    write_reg(REG_LINE_COUNT, 9'd1);
    foreach (demo[i]) begin
      note = '{1'b1, demo[i].has_res, demo[i].res_wall, demo[i].res_end};
      feed(demo[i].wall, demo[i].flush, note);
    end
    settle();

    phase_no = 0;
    while (phase_no < 3 || small_items < SMALL_ITEMS) begin
      case (phase_no)
        1: run_phase(9'd8, 9'd8, 4'd3, 4'd4, 1'b0, 1'b1);
        2: run_phase(9'd511, 9'd3, rand_threshold(), rand_threshold(), 1'b1, 1'b0);
        default: begin
          lv = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(3, 10));
          cv = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(3, 8));
          run_phase(lv, cv, rand_threshold(), rand_threshold(), 1'b0, 1'b0);
        end
      endcase
      phase_no++;
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
